// ===== rtl/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg
// shared types and constants for the nearest point search unit
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int MaxPointsDefault  = 64;
  localparam int CoordWidthDefault = 16;
  localparam int DistWidth         = 34;
  localparam int IndexWidth        = 6;
  localparam int CountWidth        = 7;
  localparam int RadiusWidth       = 17;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_KNN    = 2'd2,
    CMD_RADIUS = 2'd3
  } command_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_DIST  = 6'b000100,
    ST_SUM   = 6'b001000,
    ST_PICK  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

endpackage

// ===== rtl/nearest_point_search_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_point_search_unit
// brute-force k-nearest and radius search over a small store of 3-d points
// ----------------------------------------------------------------------------
// load and clear: no result; an empty answer is strobed next cycle
// query over n points: a distance pass (READ, DIST, SUM for each point), then
// one selection scan over the n points per result, each followed by EMIT
// a radius query that finds nothing adds one scan before its empty answer
// busy is high for the whole query; results strobed by result_valid, no stall
// synchronous reset empties the store; point and distance memories not cleared
module nearest_point_search_unit #(
  parameter int MAX_POINTS  = nps_pkg::MaxPointsDefault,
  parameter int COORD_WIDTH = nps_pkg::CoordWidthDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command,
  input  logic signed [15:0]            query_x,
  input  logic signed [15:0]            query_y,
  input  logic signed [15:0]            query_z,
  input  logic [nps_pkg::CountWidth-1:0]  neighbor_count,
  input  logic signed [nps_pkg::RadiusWidth-1:0] search_radius,
  output logic                          result_valid,
  output logic [nps_pkg::IndexWidth-1:0] point_index,
  output logic [nps_pkg::DistWidth-1:0] squared_distance,
  output logic                          last_result,
  output logic                          no_result
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = nps_pkg::DistWidth;
  localparam int SW = 2 * COORD_WIDTH + 2;   // squared term width incl. headroom

  // point memory: x, y, z packed in one word, one read port
  logic [3*COORD_WIDTH-1:0] point_mem [MAX_POINTS];
  logic [3*COORD_WIDTH-1:0] point_rd;
  // distance scratch with one read port
  logic [DW-1:0] dist_mem [MAX_POINTS];
  logic [DW-1:0] dist_rd;
  // taken flags, one per entry, so each point is reported once
  logic [MAX_POINTS-1:0] taken;

  nps_pkg::state_t state;
  logic [CW-1:0] stored_points;
  logic [CW-1:0] scan;         // read address counter during a pass
  logic [CW-1:0] rd_idx;       // index of the data now on the read port
  logic [CW-1:0] remaining;    // results still to give
  logic          is_radius;
  logic [DW-1:0] r2;
  logic signed [COORD_WIDTH-1:0] qx, qy, qz;
  logic [SW-1:0] sqx, sqy, sqz;
  logic [DW-1:0] best_dist;
  logic [AW-1:0] best_idx;
  logic          best_found;
  logic          any_out;
  logic          mem_wr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_waddr;
  logic          pick_phase;   // selection pass: the read stage trails scan by one read register

  assign busy = (state != nps_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    point_rd <= point_mem[scan[AW-1:0]];
    // forward the last distance write when the scan reads it back right away
    dist_rd  <= (mem_wr && mem_waddr == scan[AW-1:0]) ? mem_wdata
                : dist_mem[scan[AW-1:0]];
    if (start && !busy && command == nps_pkg::CMD_LOAD && stored_points < CW'(MAX_POINTS))
      point_mem[stored_points[AW-1:0]] <= {query_x[COORD_WIDTH-1:0],
                                           query_y[COORD_WIDTH-1:0],
                                           query_z[COORD_WIDTH-1:0]};
    if (mem_wr)
      dist_mem[mem_waddr] <= mem_wdata;
  end

  // coordinate differences from the registered read word
  logic signed [COORD_WIDTH:0] dx, dy, dz;
  always_comb begin
    dx = $signed({point_rd[3*COORD_WIDTH-1], point_rd[3*COORD_WIDTH-1:2*COORD_WIDTH]})
       - $signed({qx[COORD_WIDTH-1], qx});
    dy = $signed({point_rd[2*COORD_WIDTH-1], point_rd[2*COORD_WIDTH-1:COORD_WIDTH]})
       - $signed({qy[COORD_WIDTH-1], qy});
    dz = $signed({point_rd[COORD_WIDTH-1], point_rd[COORD_WIDTH-1:0]})
       - $signed({qz[COORD_WIDTH-1], qz});
  end

  logic [DW-1:0] sum_d;
  assign sum_d = DW'(sqx) + DW'(sqy) + DW'(sqz);

  logic [DW-1:0] radius_sq;
  assign radius_sq = DW'($unsigned(search_radius[nps_pkg::RadiusWidth-2:0])
                     * $unsigned(search_radius[nps_pkg::RadiusWidth-2:0]));

  // candidate check during selection: not taken, within radius (radius queries), strictly better
  logic cand_ok;
  assign cand_ok = !taken[rd_idx[AW-1:0]] && !(is_radius && dist_rd > r2)
                   && (!best_found || dist_rd < best_dist);

  always_ff @(posedge clk) begin
    mem_wr       <= 1'b0;
    result_valid <= 1'b0;
    if (rst) begin
      state         <= nps_pkg::ST_IDLE;
      stored_points <= '0;
    end else begin
      case (state)
        nps_pkg::ST_IDLE: begin
          if (start) begin
            qx <= query_x[COORD_WIDTH-1:0];
            qy <= query_y[COORD_WIDTH-1:0];
            qz <= query_z[COORD_WIDTH-1:0];
            is_radius <= (command == nps_pkg::CMD_RADIUS);
            r2 <= radius_sq;
            // radius queries count qualifying points during the distance pass
            remaining <= (command == nps_pkg::CMD_RADIUS) ? '0
                         : (neighbor_count > nps_pkg::CountWidth'(stored_points))
                           ? stored_points : CW'(neighbor_count);
            scan <= '0;
            taken <= '0;
            any_out <= 1'b0;
            case (command)
              nps_pkg::CMD_CLEAR: stored_points <= '0;
              nps_pkg::CMD_LOAD:
                if (stored_points < CW'(MAX_POINTS)) stored_points <= stored_points + 1'b1;
              nps_pkg::CMD_KNN: begin
                if (neighbor_count == '0 || stored_points == '0) begin
                  result_valid <= 1'b1; point_index <= '0; squared_distance <= '0;
                  last_result <= 1'b1; no_result <= 1'b1;
                end else state <= nps_pkg::ST_READ;
              end
              nps_pkg::CMD_RADIUS: begin
                if (search_radius[nps_pkg::RadiusWidth-1] || stored_points == '0) begin
                  result_valid <= 1'b1; point_index <= '0; squared_distance <= '0;
                  last_result <= 1'b1; no_result <= 1'b1;
                end else begin
                  state <= nps_pkg::ST_READ;
                end
              end
              default: ;
            endcase
          end
        end
        // distance pass: read, square, sum and write back, one point at a time
        nps_pkg::ST_READ: begin
          rd_idx <= scan;
          state  <= nps_pkg::ST_DIST;
        end
        nps_pkg::ST_DIST: begin
          sqx <= $unsigned(SW'(dx) * SW'(dx));
          sqy <= $unsigned(SW'(dy) * SW'(dy));
          sqz <= $unsigned(SW'(dz) * SW'(dz));
          state <= nps_pkg::ST_SUM;
        end
        nps_pkg::ST_SUM: begin
          mem_wr    <= 1'b1;
          mem_waddr <= rd_idx[AW-1:0];
          mem_wdata <= sum_d;
          if (is_radius && sum_d <= r2) remaining <= remaining + 1'b1;
          if (scan + 1'b1 == stored_points) begin
            scan       <= '0;
            pick_phase <= 1'b0;
            best_found <= 1'b0;
            state      <= nps_pkg::ST_PICK;
          end else begin
            scan  <= scan + 1'b1;
            state <= nps_pkg::ST_READ;
          end
        end
        // selection pass: smallest untaken distance, lower index on ties
        nps_pkg::ST_PICK: begin
          if (scan != stored_points) begin
            rd_idx <= scan;
            scan   <= scan + 1'b1;
          end
          pick_phase <= 1'b1;
          if (pick_phase && cand_ok) begin
            best_found <= 1'b1;
            best_dist  <= dist_rd;
            best_idx   <= rd_idx[AW-1:0];
          end
          if (pick_phase && rd_idx + 1'b1 == stored_points) state <= nps_pkg::ST_EMIT;
        end
        nps_pkg::ST_EMIT: begin
          logic fin;
          fin = !best_found || remaining == CW'(1);
          if (best_found) begin
            result_valid     <= 1'b1;
            point_index      <= nps_pkg::IndexWidth'(best_idx);
            squared_distance <= best_dist;
            last_result      <= fin;
            no_result        <= 1'b0;
            taken[best_idx]  <= 1'b1;
            any_out          <= 1'b1;
            remaining        <= remaining - 1'b1;
          end else if (!any_out) begin
            result_valid <= 1'b1; point_index <= '0; squared_distance <= '0;
            last_result <= 1'b1; no_result <= 1'b1;
          end
          scan       <= '0;
          rd_idx     <= '0;
          pick_phase <= 1'b0;
          best_found <= 1'b0;
          state      <= fin ? nps_pkg::ST_IDLE : nps_pkg::ST_PICK;
        end
        default: state <= nps_pkg::ST_IDLE;
      endcase
    end
  end

endmodule
